>>> rtl/polyline_arc_length_interpolator_core_macros.svh
// Assertion macros for the polyline arc-length interpolator.
// Expect clk and arst_n in the scope of each use.
`ifndef POLYLINE_ARC_LENGTH_INTERPOLATOR_CORE_MACROS_SVH
`define POLYLINE_ARC_LENGTH_INTERPOLATOR_CORE_MACROS_SVH

`define PALI_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define PALI_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/pali_pkg.sv
// Package for the polyline arc-length interpolator: payload types, table sizes,
// shared-unit request and response types. No dependencies.
`default_nettype none
package pali_pkg;

	localparam int MAX_WP = 32;
	localparam int AW = $clog2(MAX_WP);
	localparam int CW = $clog2(MAX_WP + 1);
	localparam logic [21:0] LEN_MAX = 22'h3FFFFF;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tile_x;
		logic [7:0]  tile_y;
		logic [16:0] progress;
	} in_t;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [21:0] path_length;
	} out_t;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
	} wp_t;

	typedef enum logic {
		MODE_SQRT = 1'b0,
		MODE_DIV  = 1'b1
	} unit_mode_t;

	typedef struct packed {
		logic        start;
		unit_mode_t  mode;
		logic [33:0] opa;
		logic [16:0] divisor;
	} unit_req_t;

	typedef struct packed {
		logic        done;
		logic        busy;
		logic [17:0] result;
	} unit_rsp_t;

	function automatic logic [15:0] coord(input logic [7:0] t);
		return {t, 8'h80};
	endfunction

endpackage
`default_nettype wire

>>> rtl/polyline_arc_length_interpolator_core.sv
// Polyline arc-length interpolator top level: sequencer, waypoint table, output register.
// Depends on pali_pkg, pali_wp_ram and pali_shift_unit.
//
// channel  dir  handshake            payload
// in       in   in_valid / in_stall  pali_pkg::in_t  (kind, tile_x, tile_y, progress)
// out      out  out_valid / out_stall pali_pkg::out_t (pos_x, pos_y, path_length)
//
// Clear, append and unused kinds are handled in the idle state without leaving it. A query
// walks the segments: each needs a table read, two squares and a 17-step square root in
// the shared unit, walked once for the total and again to find the segment; the final
// point needs two 34-step divisions in the same unit.
// in_stall is high while a query runs. Reset clears the waypoint count, the sequencer
// and the output valid; the table itself is not cleared.
`default_nettype none
module polyline_arc_length_interpolator_core (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire pali_pkg::in_t in_data,
	output logic          out_valid,
	input  wire logic     out_stall,
	output pali_pkg::out_t out_data
);
	import pali_pkg::*;

	typedef enum logic [16:0] {
		S_IDLE = 17'h00001,
		S_RD   = 17'h00002,
		S_LD   = 17'h00004,
		S_SQX  = 17'h00008,
		S_SQY  = 17'h00010,
		S_SQGO = 17'h00020,
		S_SQWT = 17'h00040,
		S_SEG  = 17'h00080,
		S_FIN0 = 17'h00100,
		S_TGT  = 17'h00200,
		S_MX   = 17'h00400,
		S_DXGO = 17'h00800,
		S_DXWT = 17'h01000,
		S_MY   = 17'h02000,
		S_DYGO = 17'h04000,
		S_DYWT = 17'h08000,
		S_OUT  = 17'h10000
	} state_t;

	state_t      state_q;
	logic [CW-1:0] cnt_q, idx_q;
	logic        pass_q;
	logic [16:0] prog_q;
	logic [15:0] first_x_q, first_y_q, prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic [15:0] adx_q, ady_q, res_x_q, res_y_q;
	logic        xneg_q, yneg_q;
	logic [33:0] sq_q;
	logic [16:0] seg_q;
	logic [22:0] acc_q, total_q;
	logic [38:0] target_q;
	logic [33:0] rem_q;
	logic [49:0] prod_q;
	logic        out_valid_q;
	out_t        out_q;

	wp_t         rd;
	logic        we;
	logic [15:0] bx, by;
	logic        last_seg;
	logic [23:0] acc_next;
	unit_req_t   ureq;
	unit_rsp_t   ursp;

	assign we = (state_q == S_IDLE) && in_valid && (in_data.kind == KIND_APPEND)
		&& (cnt_q < CW'(MAX_WP));

	pali_wp_ram u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(cnt_q[AW-1:0]),
		.wdata('{x: in_data.tile_x, y: in_data.tile_y}),
		.raddr(idx_q[AW-1:0]),
		.rdata(rd)
	);

	always_comb begin
		ureq.start = (state_q == S_SQGO) || (state_q == S_DXGO) || (state_q == S_DYGO);
		ureq.mode = (state_q == S_SQGO) ? MODE_SQRT : MODE_DIV;
		ureq.opa = (state_q == S_SQGO) ? sq_q : prod_q[49:16];
		ureq.divisor = seg_q;
	end

	pali_shift_unit u_unit (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (ureq),
		.rsp   (ursp)
	);

	assign bx = coord(rd.x);
	assign by = coord(rd.y);
	assign last_seg = (idx_q == cnt_q - CW'(1));
	assign acc_next = {1'b0, acc_q} + {7'b0, seg_q};
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (in_data.kind)
							KIND_CLEAR: cnt_q <= '0;
							KIND_APPEND: begin
								if (we) begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							KIND_QUERY: begin
								state_q <= (cnt_q == '0) ? S_OUT : S_RD;
							end
							default: ;
						endcase
					end
				end
				S_RD: state_q <= S_LD;
				S_LD: begin
					if (idx_q != '0) begin
						state_q <= S_SQX;
					end else if (cnt_q == CW'(1)) begin
						state_q <= S_FIN0;
					end else begin
						state_q <= S_RD;
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: state_q <= S_SQGO;
				S_SQGO: state_q <= S_SQWT;
				S_SQWT: begin
					if (ursp.done) begin
						state_q <= S_SEG;
					end
				end
				S_SEG: begin
					if (!pass_q) begin
						state_q <= last_seg ? S_FIN0 : S_RD;
					end else if ({acc_next, 16'b0} >= {1'b0, target_q}) begin
						state_q <= (seg_q == '0) ? S_OUT : S_MX;
					end else begin
						state_q <= last_seg ? S_OUT : S_RD;
					end
				end
				S_FIN0: begin
					if (cnt_q == CW'(1) || prog_q == '0 || acc_q == '0 || prog_q[16]) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_TGT;
					end
				end
				S_TGT: state_q <= S_RD;
				S_MX: state_q <= S_DXGO;
				S_DXGO: state_q <= S_DXWT;
				S_DXWT: begin
					if (ursp.done) begin
						state_q <= S_MY;
					end
				end
				S_MY: state_q <= S_DYGO;
				S_DYGO: state_q <= S_DYWT;
				S_DYWT: begin
					if (ursp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				prog_q <= in_data.progress;
				idx_q <= '0;
				pass_q <= 1'b0;
				acc_q <= '0;
				total_q <= '0;
				res_x_q <= '0;
				res_y_q <= '0;
			end
			S_LD: begin
				if (idx_q == '0) begin
					prev_x_q <= bx;
					prev_y_q <= by;
					if (!pass_q) begin
						first_x_q <= bx;
						first_y_q <= by;
					end
					idx_q <= CW'(1);
				end else begin
					cur_x_q <= bx;
					cur_y_q <= by;
					xneg_q <= bx < prev_x_q;
					yneg_q <= by < prev_y_q;
					adx_q <= (bx < prev_x_q) ? prev_x_q - bx : bx - prev_x_q;
					ady_q <= (by < prev_y_q) ? prev_y_q - by : by - prev_y_q;
				end
			end
			S_SQX: sq_q <= {2'b0, 32'(adx_q) * 32'(adx_q)};
			S_SQY: sq_q <= sq_q + {2'b0, 32'(ady_q) * 32'(ady_q)};
			S_SQWT: begin
				if (ursp.done) begin
					seg_q <= ursp.result[16:0];
				end
			end
			S_SEG: begin
				if (pass_q && ({acc_next, 16'b0} >= {1'b0, target_q})) begin
					rem_q <= 34'(target_q - {acc_q, 16'b0});
					res_x_q <= prev_x_q;
					res_y_q <= prev_y_q;
				end else begin
					acc_q <= acc_next[22:0];
					prev_x_q <= cur_x_q;
					prev_y_q <= cur_y_q;
					idx_q <= idx_q + CW'(1);
					res_x_q <= cur_x_q;
					res_y_q <= cur_y_q;
				end
			end
			S_FIN0: begin
				total_q <= acc_q;
				if (prog_q[16] && cnt_q != CW'(1) && prog_q != '0 && acc_q != '0) begin
					res_x_q <= prev_x_q;
					res_y_q <= prev_y_q;
				end else begin
					res_x_q <= first_x_q;
					res_y_q <= first_y_q;
				end
			end
			S_TGT: begin
				target_q <= prog_q[15:0] * acc_q;
				acc_q <= '0;
				pass_q <= 1'b1;
				idx_q <= '0;
			end
			S_MX: prod_q <= adx_q * rem_q;
			S_DXWT: begin
				if (ursp.done) begin
					res_x_q <= xneg_q ? prev_x_q - ursp.result[15:0]
						: prev_x_q + ursp.result[15:0];
				end
			end
			S_MY: prod_q <= ady_q * rem_q;
			S_DYWT: begin
				if (ursp.done) begin
					res_y_q <= yneg_q ? prev_y_q - ursp.result[15:0]
						: prev_y_q + ursp.result[15:0];
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_q.pos_x <= res_x_q;
					out_q.pos_y <= res_y_q;
					out_q.path_length <= (total_q > {1'b0, LEN_MAX}) ? LEN_MAX : total_q[21:0];
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

>>> rtl/pali_wp_ram.sv
// Waypoint table: one write port, one registered read port.
// Depends on pali_pkg.
`default_nettype none
module pali_wp_ram (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [pali_pkg::AW-1:0] waddr,
	input  wire pali_pkg::wp_t          wdata,
	input  wire logic [pali_pkg::AW-1:0] raddr,
	output pali_pkg::wp_t               rdata
);
	import pali_pkg::*;

	wp_t mem [MAX_WP];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/pali_shift_unit.sv
// Shared shift-and-subtract unit: bitwise square root and restoring division.
// Depends on pali_pkg and the assertion macro header.
`default_nettype none
`include "polyline_arc_length_interpolator_core_macros.svh"
module pali_shift_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pali_pkg::unit_req_t req,
	output pali_pkg::unit_rsp_t rsp
);
	import pali_pkg::*;

	logic        busy_q, done_q;
	unit_mode_t  mode_q;
	logic [5:0]  cnt_q;
	logic [34:0] a_q, b_q, c_q;
	logic [16:0] d_q;
	logic [17:0] r2;
	logic [34:0] lhs, sub, diff;
	logic        ge;

	always_comb begin
		r2 = {b_q[16:0], a_q[33]};
		if (mode_q == MODE_DIV) begin
			lhs = {17'b0, r2};
			sub = {18'b0, d_q};
		end else begin
			lhs = a_q;
			sub = b_q + c_q;
		end
		ge = lhs >= sub;
		diff = lhs - sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == 6'd0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= (req.mode == MODE_DIV) ? 6'd33 : 6'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mode_q <= req.mode;
			a_q <= {1'b0, req.opa};
			b_q <= '0;
			c_q <= (req.mode == MODE_DIV) ? 35'd0 : 35'h1_0000_0000;
			d_q <= req.divisor;
		end else if (busy_q) begin
			if (mode_q == MODE_DIV) begin
				a_q <= {a_q[33:0], 1'b0};
				b_q <= ge ? diff : {17'b0, r2};
				c_q <= {c_q[33:0], ge};
			end else begin
				if (ge) begin
					a_q <= diff;
					b_q <= (b_q >> 1) + c_q;
				end else begin
					b_q <= b_q >> 1;
				end
				c_q <= c_q >> 2;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign rsp.result = (mode_q == MODE_DIV) ? c_q[17:0] : b_q[17:0];

	`PALI_IMPLIES(a_no_restart, req.start, !busy_q, "unit started while busy")
	`PALI_IMPLIES(a_done_idle, done_q, !busy_q, "unit done while still busy")
	`PALI_IMPLIES(a_div_nonzero, req.start && (req.mode == MODE_DIV), req.divisor != 17'd0,
		"division by zero")

endmodule
`default_nettype wire

>>> tb/sv/polyline_arc_length_interpolator_core_tb.sv
// Self-checking testbench for polyline_arc_length_interpolator_core: drives clear,
// append, query and unused-kind transfers, predicts each query result and compares it
// field by field. Depends on pali_pkg and the RTL of the core.
`default_nettype none
module polyline_arc_length_interpolator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pali_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int TABLE_DEPTH = 32;
	localparam logic [16:0] PROG_ONE = 17'd65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;

	polyline_arc_length_interpolator_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #6 clk = ~clk;

	logic [7:0] wp_x [TABLE_DEPTH];
	logic [7:0] wp_y [TABLE_DEPTH];
	int wp_count = 0;
	out_t expected_points [$];
	int fail_count = 0;
	int hold_off_cycles = 0;
	bit stall_free = 1'b0;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned center(logic [7:0] t);
		return (longint'(t) << 8) + 128;
	endfunction

	function automatic longint unsigned segment_length(int i);
		longint unsigned ax, bx, ay, by, dx, dy;
		ax = center(wp_x[i - 1]);
		bx = center(wp_x[i]);
		ay = center(wp_y[i - 1]);
		by = center(wp_y[i]);
		dx = ax > bx ? ax - bx : bx - ax;
		dy = ay > by ? ay - by : by - ay;
		return int_sqrt(dx * dx + dy * dy);
	endfunction

	function automatic longint unsigned step_toward(longint unsigned a, longint unsigned b,
			longint unsigned num, longint unsigned den);
		if (b >= a)
			return a + ((b - a) * num) / den;
		return a - ((a - b) * num) / den;
	endfunction

	function automatic out_t locate_point(logic [16:0] prog);
		out_t r;
		longint unsigned total, px, py, target, acc, seg, rem, den;
		int last;
		bit found;
		total = 0;
		px = 0;
		py = 0;
		for (int i = 1; i < wp_count; i++)
			total += segment_length(i);
		if (wp_count != 0) begin
			last = wp_count - 1;
			px = center(wp_x[0]);
			py = center(wp_y[0]);
			if (wp_count == 1 || prog == 0 || total == 0) begin
			end else if (prog >= PROG_ONE) begin
				px = center(wp_x[last]);
				py = center(wp_y[last]);
			end else begin
				target = longint'(prog) * total;
				acc = 0;
				found = 1'b0;
				for (int i = 1; i < wp_count && !found; i++) begin
					seg = segment_length(i);
					if (((acc + seg) << 16) >= target) begin
						found = 1'b1;
						px = center(wp_x[i - 1]);
						py = center(wp_y[i - 1]);
						if (seg != 0) begin
							rem = target - (acc << 16);
							den = seg << 16;
							px = step_toward(px, center(wp_x[i]), rem, den);
							py = step_toward(py, center(wp_y[i]), rem, den);
						end
					end
					acc += seg;
				end
				if (!found) begin
					px = center(wp_x[last]);
					py = center(wp_y[last]);
				end
			end
		end
		r.pos_x = px[15:0];
		r.pos_y = py[15:0];
		r.path_length = total > longint'(LEN_MAX) ? LEN_MAX : total[21:0];
		return r;
	endfunction

	function automatic void apply_item(in_t it);
		case (it.kind)
			KIND_CLEAR: wp_count = 0;
			KIND_APPEND: begin
				if (wp_count < TABLE_DEPTH) begin
					wp_x[wp_count] = it.tile_x;
					wp_y[wp_count] = it.tile_y;
					wp_count++;
				end
			end
			KIND_QUERY: expected_points.push_back(locate_point(it.progress));
			default: ;
		endcase
	endfunction

	task automatic send_item(in_t it);
		int gap;
		bit taken;
		gap = $urandom_range(0, 13);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		apply_item(it);
	endtask

	task automatic send(logic [1:0] k, logic [7:0] x, logic [7:0] y, logic [16:0] p);
		in_t it;
		it.kind = k;
		it.tile_x = x;
		it.tile_y = y;
		it.progress = p;
		send_item(it);
	endtask

	function automatic logic [16:0] rand_progress();
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return PROG_ONE;
			2: return 17'($urandom_range(65537, 131071));
			3: return 17'($urandom_range(1, 15));
			default: return 17'($urandom_range(1, 65535));
		endcase
	endfunction

	// result side: sample between edges, check on the accepting edge
	always begin : result_check
		logic v, s;
		out_t d, e;
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			v = out_valid;
			s = out_stall;
			d = out_data;
			@(posedge clk);
			if (v && !s) begin
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected result %h", $time, d);
					fail_count++;
				end else begin
					e = expected_points.pop_front();
					if (d.pos_x !== e.pos_x) begin
						$display("%0t: pos_x exp %h got %h", $time, e.pos_x, d.pos_x);
						fail_count++;
					end
					if (d.pos_y !== e.pos_y) begin
						$display("%0t: pos_y exp %h got %h", $time, e.pos_y, d.pos_y);
						fail_count++;
					end
					if (d.path_length !== e.path_length) begin
						$display("%0t: path_length exp %h got %h", $time,
							e.path_length, d.path_length);
						fail_count++;
					end
				end
				stall_left = stall_free ? 0 : $urandom_range(0, 13);
			end
			if (hold_off_cycles > 0) begin
				out_stall <= 1'b1;
				hold_off_cycles--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic test_empty_and_single();
		send(KIND_QUERY, 8'd0, 8'd0, 17'd32768);
		send(KIND_APPEND, 8'd0, 8'd0, 17'd0);
		send(KIND_QUERY, 8'd0, 8'd0, 17'd32768);
		send(KIND_UNUSED, 8'hFF, 8'hFF, 17'h1FFFF);
		send(KIND_CLEAR, 8'hFF, 8'hFF, 17'h1FFFF);
		send(KIND_QUERY, 8'd0, 8'd0, PROG_ONE);
	endtask

	task automatic test_extremes();
		send(KIND_APPEND, 8'd0, 8'd0, 17'd0);
		send(KIND_APPEND, 8'd255, 8'd255, 17'd0);
		send(KIND_APPEND, 8'd255, 8'd255, 17'd0);
		send(KIND_APPEND, 8'd0, 8'd255, 17'd0);
		send(KIND_QUERY, 8'd0, 8'd0, 17'd0);
		send(KIND_QUERY, 8'd0, 8'd0, 17'd1);
		send(KIND_QUERY, 8'd0, 8'd0, 17'd32768);
		send(KIND_QUERY, 8'd0, 8'd0, 17'd65535);
		send(KIND_QUERY, 8'd0, 8'd0, PROG_ONE);
		send(KIND_QUERY, 8'd0, 8'd0, 17'h1FFFF);
		send(KIND_QUERY, 8'd0, 8'd0, 17'd43000);
	endtask

	task automatic test_zero_length();
		send(KIND_CLEAR, 8'd0, 8'd0, 17'd0);
		send(KIND_APPEND, 8'd7, 8'd9, 17'd0);
		send(KIND_APPEND, 8'd7, 8'd9, 17'd0);
		send(KIND_QUERY, 8'd0, 8'd0, 17'd32768);
	endtask

	task automatic test_full_table();
		send(KIND_CLEAR, 8'd0, 8'd0, 17'd0);
		for (int i = 0; i < TABLE_DEPTH + 3; i++)
			send(KIND_APPEND, 8'($urandom), 8'($urandom), 17'($urandom));
		send(KIND_QUERY, 8'd0, 8'd0, rand_progress());
		send(KIND_QUERY, 8'd0, 8'd0, PROG_ONE);
	endtask

	task automatic test_random_paths(int target_items);
		int sent, n;
		sent = 0;
		while (sent < target_items) begin
			stall_free = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 6)) begin
					send(2'($urandom), 8'($urandom), 8'($urandom), 17'($urandom));
					sent++;
				end
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34)
					: $urandom_range(0, 6);
				send(KIND_CLEAR, 8'($urandom), 8'($urandom), 17'($urandom));
				repeat (n) send(KIND_APPEND, 8'($urandom), 8'($urandom), 17'($urandom));
				repeat ($urandom_range(1, 4)) begin
					send(KIND_QUERY, 8'($urandom), 8'($urandom), rand_progress());
					sent++;
				end
				sent += n + 1;
			end
		end
		stall_free = 1'b0;
	endtask

	task automatic test_output_hold_off();
		send(KIND_CLEAR, 8'd0, 8'd0, 17'd0);
		repeat (3) send(KIND_APPEND, 8'($urandom), 8'($urandom), 17'd0);
		hold_off_cycles = 3000;
		repeat (4) send(KIND_QUERY, 8'd0, 8'd0, rand_progress());
	endtask

	initial begin : limit
		#40ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_single();
		test_extremes();
		test_zero_length();
		test_full_table();
		test_output_hold_off();
		test_random_paths(400);
		in_valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (1700) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
